// File: hdl/pdsr_pkg.sv
// ----------------------------------------------------------------------------
// pdsr_pkg
// shared types and codes of the peak detector spi readout
// ----------------------------------------------------------------------------
package pdsr_pkg;

   localparam int AmpWidth   = 16;
   localparam int ByteWidth  = 8;
   localparam int CountWidth = 32;

   // operation codes
   localparam logic [1:0] OP_HIT  = 2'd0;
   localparam logic [1:0] OP_LINE = 2'd1;
   localparam logic [1:0] OP_SPI  = 2'd2;

   // hit fate codes
   localparam logic [1:0] FATE_NONE    = 2'd0;
   localparam logic [1:0] FATE_LATCHED = 2'd1;
   localparam logic [1:0] FATE_PILEUP  = 2'd2;
   localparam logic [1:0] FATE_RESET   = 2'd3;

   // read event codes
   localparam logic [1:0] READ_NONE  = 2'd0;
   localparam logic [1:0] READ_VALID = 2'd1;
   localparam logic [1:0] READ_EMPTY = 2'd2;

   // spi byte index positions
   localparam logic [1:0] IDX_HIGH = 2'd0;
   localparam logic [1:0] IDX_LOW  = 2'd1;
   localparam logic [1:0] IDX_DONE = 2'd2;

   localparam logic [ByteWidth-1:0] BYTE_MASK = 8'hff;

   typedef struct packed {
      logic [1:0]          operation;
      logic [AmpWidth-1:0] hit_value;
      logic                reset_level;
   } pdsr_item_type;

   typedef struct packed {
      logic                 convert_flag;
      logic [ByteWidth-1:0] spi_byte;
      logic [1:0]           hit_fate;
      logic [1:0]           read_event;
   } pdsr_event_type;

   typedef struct packed {
      logic generated;
      logic lost_reset;
      logic pileup;
      logic word_read;
      logic blank_read;
   } pdsr_inc_type;

   typedef struct packed {
      logic [CountWidth-1:0] generated;
      logic [CountWidth-1:0] lost_reset;
      logic [CountWidth-1:0] pileup;
      logic [CountWidth-1:0] word_read;
      logic [CountWidth-1:0] blank_read;
   } pdsr_count_type;

endpackage

// File: hdl/pdsr_if.sv
// ----------------------------------------------------------------------------
// pdsr request and response channels
// valid/ready channels carrying one item each
// ----------------------------------------------------------------------------
interface pdsr_req_if;
   import pdsr_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [AmpWidth-1:0] hit_value;
   logic                reset_level;

   modport source (output valid, output operation, output hit_value,
                   output reset_level, input ready);
   modport sink   (input valid, input operation, input hit_value,
                   input reset_level, output ready);
endinterface

interface pdsr_rsp_if;
   import pdsr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  convert_flag;
   logic [ByteWidth-1:0]  spi_byte;
   logic [1:0]            hit_fate;
   logic [1:0]            read_event;
   logic [CountWidth-1:0] count_generated;
   logic [CountWidth-1:0] count_lost_reset;
   logic [CountWidth-1:0] count_pileup;
   logic [CountWidth-1:0] count_read_valid;
   logic [CountWidth-1:0] count_read_empty;

   modport source (output valid, output convert_flag, output spi_byte,
                   output hit_fate, output read_event, output count_generated,
                   output count_lost_reset, output count_pileup,
                   output count_read_valid, output count_read_empty,
                   input ready);
   modport sink   (input valid, input convert_flag, input spi_byte,
                   input hit_fate, input read_event, input count_generated,
                   input count_lost_reset, input count_pileup,
                   input count_read_valid, input count_read_empty,
                   output ready);
endinterface

// File: hdl/pdsr_core.sv
// ----------------------------------------------------------------------------
// pdsr_core
// peak holder, reset line tracking and spi shift word
// ----------------------------------------------------------------------------
module pdsr_core
   import pdsr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  pdsr_item_type  item,
   output pdsr_event_type evt,
   output pdsr_inc_type   inc
);

   logic [AmpWidth-1:0] held_ff, held_in;
   logic                flag_ff, flag_in;
   logic                line_ff, line_in;
   logic [1:0]          idx_ff, idx_in;
   logic [AmpWidth-1:0] shift_ff, shift_in;

   always_comb begin
      held_in  = held_ff;
      flag_in  = flag_ff;
      line_in  = line_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      inc      = '0;
      evt.spi_byte   = '0;
      evt.hit_fate   = FATE_NONE;
      evt.read_event = READ_NONE;
      unique case (item.operation)
         OP_HIT: begin
            inc.generated = 1'b1;
            if (!line_ff) begin
               inc.lost_reset = 1'b1;
               evt.hit_fate   = FATE_RESET;
            end else if (flag_ff) begin
               inc.pileup   = 1'b1;
               evt.hit_fate = FATE_PILEUP;
            end else begin
               held_in      = item.hit_value;
               flag_in      = 1'b1;
               evt.hit_fate = FATE_LATCHED;
            end
         end
         OP_LINE: begin
            if (item.reset_level != line_ff) begin
               line_in = item.reset_level;
               // falling edge loads the shift word
               if (!item.reset_level) begin
                  idx_in  = IDX_HIGH;
                  flag_in = 1'b0;
                  if (flag_ff) begin
                     shift_in       = held_ff;
                     inc.word_read  = 1'b1;
                     evt.read_event = READ_VALID;
                  end else begin
                     shift_in       = '0;
                     inc.blank_read = 1'b1;
                     evt.read_event = READ_EMPTY;
                  end
               end
            end
         end
         OP_SPI: begin
            if (idx_ff == IDX_HIGH) begin
               evt.spi_byte = shift_ff[AmpWidth-1 -: ByteWidth] & BYTE_MASK;
            end else if (idx_ff == IDX_LOW) begin
               evt.spi_byte = shift_ff[ByteWidth-1:0] & BYTE_MASK;
            end
            if (idx_ff != IDX_DONE) begin
               idx_in = idx_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
      evt.convert_flag = flag_in;
      if (!fire) begin
         inc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         flag_ff  <= 1'b0;
         line_ff  <= 1'b1;
         idx_ff   <= IDX_HIGH;
         shift_ff <= '0;
      end else if (fire) begin
         held_ff  <= held_in;
         flag_ff  <= flag_in;
         line_ff  <= line_in;
         idx_ff   <= idx_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// File: hdl/pdsr_counters.sv
// ----------------------------------------------------------------------------
// pdsr_counters
// five wrapping statistics counters
// ----------------------------------------------------------------------------
module pdsr_counters
   import pdsr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  pdsr_inc_type   inc,
   output pdsr_count_type count_in
);

   pdsr_count_type count_ff;

   always_comb begin
      count_in.generated  = count_ff.generated  + CountWidth'(inc.generated);
      count_in.lost_reset = count_ff.lost_reset + CountWidth'(inc.lost_reset);
      count_in.pileup     = count_ff.pileup     + CountWidth'(inc.pileup);
      count_in.word_read  = count_ff.word_read  + CountWidth'(inc.word_read);
      count_in.blank_read = count_ff.blank_read + CountWidth'(inc.blank_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/peak_detector_spi_readout.sv
// ----------------------------------------------------------------------------
// peak_detector_spi_readout
// digital side of a peak-hold adc with spi readout and event statistics
// ----------------------------------------------------------------------------
// One item in, one result out. Each item is a hit, a reset line sample or an
// spi byte transfer; the result reports the convert flag after the item, the
// spi byte, what became of a hit, any readout event and all five counters
// after the item. Throughput is one item per clock while the result is not
// stalled: the item is captured in an input register, evaluated by the core
// and counters, and placed in a result register, from which it is presented.
// A stalled result holds the result register; the input register still takes
// one more item behind it before req ready drops.
// After reset the line is released, nothing is latched and counters are 0.
module peak_detector_spi_readout
   import pdsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   pdsr_req_if.sink          req_bus,
   pdsr_rsp_if.source        rsp_bus
);

   // input stage
   logic          s1_valid_ff, s1_valid_in;
   pdsr_item_type s1_item_ff;

   // result stage
   logic           rsp_valid_ff, rsp_valid_in;
   pdsr_event_type rsp_evt_ff;
   pdsr_count_type rsp_count_ff;

   logic           out_free;
   logic           s1_move;
   logic           req_take;
   pdsr_event_type evt;
   pdsr_inc_type   inc;
   pdsr_count_type count_in;

   // handshake: a stage moves when the one after it is free
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move         = s1_valid_ff && out_free;
   assign req_bus.ready   = !s1_valid_ff || out_free;
   assign req_take        = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.operation   <= req_bus.operation;
         s1_item_ff.hit_value   <= req_bus.hit_value;
         s1_item_ff.reset_level <= req_bus.reset_level;
      end
      if (s1_move) begin
         rsp_evt_ff   <= evt;
         rsp_count_ff <= count_in;
      end
   end

   // detector state, updated only when the item moves to the result stage
   pdsr_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (s1_move),
      .item  (s1_item_ff),
      .evt   (evt),
      .inc   (inc)
   );

   // statistics, increments are already gated by the core
   pdsr_counters u_counters (
      .clock    (clock),
      .reset    (reset),
      .inc      (inc),
      .count_in (count_in)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.convert_flag     = rsp_evt_ff.convert_flag;
   assign rsp_bus.spi_byte         = rsp_evt_ff.spi_byte;
   assign rsp_bus.hit_fate         = rsp_evt_ff.hit_fate;
   assign rsp_bus.read_event       = rsp_evt_ff.read_event;
   assign rsp_bus.count_generated  = rsp_count_ff.generated;
   assign rsp_bus.count_lost_reset = rsp_count_ff.lost_reset;
   assign rsp_bus.count_pileup     = rsp_count_ff.pileup;
   assign rsp_bus.count_read_valid = rsp_count_ff.word_read;
   assign rsp_bus.count_read_empty = rsp_count_ff.blank_read;

   // both stages empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // a latched hit always leaves the convert flag raised
   a_latch_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evt_ff.hit_fate == FATE_LATCHED) |-> rsp_evt_ff.convert_flag)
      else $error("latched hit without convert flag");

   // a readout clears the convert flag
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evt_ff.read_event != READ_NONE) |-> !rsp_evt_ff.convert_flag)
      else $error("convert flag set after readout");

   // full pipeline with stalled output takes no item
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("item taken while pipeline full");

   // an item leaving the input stage shows up as a result
   a_move_result: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("moved item lost");

endmodule
